>>> rtl/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg
// Shared widths and the fixed discharge curve of the battery level block.
// ----------------------------------------------------------------------------
package bli_pkg;

    localparam int TABLE_LEN = 21;  // points held in the curve table
    localparam int IDX_W     = 5;   // index into the curve table
    localparam int IN_W      = 16;  // input voltage word, mV
    localparam int MV_W      = 13;  // curve voltages, mV (up to 4200)
    localparam int LVL_W     = 14;  // levels, parts per ten thousand
    localparam int PROD_W    = LVL_W + MV_W;  // level span times voltage offset

    // Curve voltage of one point, highest voltage first.
    function automatic logic [MV_W-1:0] curve_mv(input logic [IDX_W-1:0] idx);
        logic [MV_W-1:0] v;
        case (idx)
            5'd0:    v = 13'd4200;
            5'd1:    v = 13'd4150;
            5'd2:    v = 13'd4110;
            5'd3:    v = 13'd4080;
            5'd4:    v = 13'd4020;
            5'd5:    v = 13'd3980;
            5'd6:    v = 13'd3950;
            5'd7:    v = 13'd3910;
            5'd8:    v = 13'd3870;
            5'd9:    v = 13'd3850;
            5'd10:   v = 13'd3840;
            5'd11:   v = 13'd3820;
            5'd12:   v = 13'd3800;
            5'd13:   v = 13'd3790;
            5'd14:   v = 13'd3770;
            5'd15:   v = 13'd3750;
            5'd16:   v = 13'd3730;
            5'd17:   v = 13'd3710;
            5'd18:   v = 13'd3690;
            5'd19:   v = 13'd3610;
            5'd20:   v = 13'd3270;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    // Charge level of one point, in parts per ten thousand.
    function automatic logic [LVL_W-1:0] curve_pptt(input logic [IDX_W-1:0] idx);
        logic [LVL_W-1:0] l;
        case (idx)
            5'd0:    l = 14'd10000;
            5'd1:    l = 14'd9500;
            5'd2:    l = 14'd9000;
            5'd3:    l = 14'd8500;
            5'd4:    l = 14'd8000;
            5'd5:    l = 14'd7500;
            5'd6:    l = 14'd7000;
            5'd7:    l = 14'd6500;
            5'd8:    l = 14'd6000;
            5'd9:    l = 14'd5500;
            5'd10:   l = 14'd5000;
            5'd11:   l = 14'd4500;
            5'd12:   l = 14'd4000;
            5'd13:   l = 14'd3500;
            5'd14:   l = 14'd3000;
            5'd15:   l = 14'd2500;
            5'd16:   l = 14'd2000;
            5'd17:   l = 14'd1500;
            5'd18:   l = 14'd1000;
            5'd19:   l = 14'd500;
            5'd20:   l = 14'd0;
            default: l = 14'd0;
        endcase
        return l;
    endfunction

endpackage

>>> rtl/bli_div.sv
// ----------------------------------------------------------------------------
// bli_div
// Restoring serial divider: one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module bli_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [bli_pkg::PROD_W-1:0]      i_num,
    input  logic [bli_pkg::MV_W-1:0]        i_den,
    output logic                            o_done,
    output logic [bli_pkg::LVL_W-1:0]       o_quo
);

    localparam int CNT_W = $clog2(bli_pkg::PROD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(bli_pkg::PROD_W - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [bli_pkg::MV_W-1:0]   r_rem;
    logic [bli_pkg::PROD_W-1:0] r_num;
    logic [bli_pkg::MV_W-1:0]   r_den;

    logic [bli_pkg::MV_W:0]     trial;
    logic                       ge;

    // Bring down the next dividend bit and try the subtract.
    assign trial = {r_rem, r_num[bli_pkg::PROD_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= LAST_STEP;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift into the dividend register as it empties.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? bli_pkg::MV_W'(trial - {1'b0, r_den})
                        : trial[bli_pkg::MV_W-1:0];
            r_num <= {r_num[bli_pkg::PROD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num[bli_pkg::LVL_W-1:0];

endmodule

>>> rtl/battery_level_interpolator.sv
// ----------------------------------------------------------------------------
// battery_level_interpolator
// Battery charge level from voltage over a fixed piecewise linear curve.
// ----------------------------------------------------------------------------
// Pulse start with a voltage word on i_battery_mv while busy is low; busy
// rises at once and o_valid, high for a single cycle, marks the level word on
// o_level_pptt, after which busy falls. The receiver cannot
// stall: take the word in the cycle o_valid is high or lose it. From
// the accepting edge to the o_valid cycle: a voltage at or above the top
// point goes straight to output; otherwise the table search visits curve
// points (one compare per cycle, up to 20), and when the point it hits has
// a segment above it that is not flat, the level is interpolated: a multiply
// state, a state to launch the serial divider, its one-bit-per-cycle
// restoring divide, then the output once its registered done flag is seen.
// ----------------------------------------------------------------------------
module battery_level_interpolator #(
    parameter int CURVE_POINTS = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [bli_pkg::IN_W-1:0]    i_battery_mv,
    output logic                        busy,
    output logic                        o_valid,
    output logic [bli_pkg::LVL_W-1:0]   o_level_pptt
);

    // Points beyond the table are never searched.
    localparam int N_EFF = (CURVE_POINTS > bli_pkg::TABLE_LEN) ?
                           bli_pkg::TABLE_LEN : CURVE_POINTS;
    localparam logic [bli_pkg::IDX_W-1:0] LAST_IDX = bli_pkg::IDX_W'(N_EFF - 1);

    // Sequencer codes.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIVGO  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]                     r_state, n_state;
    logic [bli_pkg::IN_W-1:0]       r_mv;
    logic [bli_pkg::IDX_W-1:0]      r_idx;
    logic [bli_pkg::LVL_W-1:0]      r_dl;     // level span of the segment
    logic [bli_pkg::MV_W-1:0]       r_dv;     // input above the lower point
    logic [bli_pkg::MV_W-1:0]       r_den;    // voltage span of the segment
    logic [bli_pkg::LVL_W-1:0]      r_base;   // level of the lower point
    logic [bli_pkg::PROD_W-1:0]     r_prod;
    logic [bli_pkg::LVL_W-1:0]      r_level;

    logic [bli_pkg::MV_W-1:0]       lo_v, hi_v;
    logic [bli_pkg::LVL_W-1:0]      lo_l, hi_l;
    logic                           hit;
    logic                           flat;
    logic                           div_done;
    logic [bli_pkg::LVL_W-1:0]      div_quo;

    // Current segment: point r_idx and the point above it.
    always_comb begin
        lo_v = bli_pkg::curve_mv(r_idx);
        hi_v = bli_pkg::curve_mv(r_idx - 1'b1);
        lo_l = bli_pkg::curve_pptt(r_idx);
        hi_l = bli_pkg::curve_pptt(r_idx - 1'b1);
        hit  = r_mv >= {{(bli_pkg::IN_W - bli_pkg::MV_W){1'b0}}, lo_v};
        flat = (hi_v <= lo_v) || (hi_l < lo_l);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_battery_mv >= {{(bli_pkg::IN_W - bli_pkg::MV_W){1'b0}},
                                         bli_pkg::curve_mv('0)})
                        n_state = S_OUT;
                    else
                        n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit)
                    n_state = flat ? S_OUT : S_MUL;
                else if (r_idx == LAST_IDX)
                    n_state = S_OUT;
            end
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV: begin
                if (div_done)
                    n_state = S_OUT;
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // Datapath: hold the word, walk down the curve, then interpolate.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mv    <= i_battery_mv;
                r_idx   <= bli_pkg::IDX_W'(1);
                r_level <= bli_pkg::curve_pptt('0);   // cap at the top point
            end
            S_SEARCH: begin
                if (hit) begin
                    r_base  <= lo_l;
                    r_level <= lo_l;                   // used on a flat segment
                    r_dl    <= hi_l - lo_l;
                    r_dv    <= bli_pkg::MV_W'(r_mv - {{(bli_pkg::IN_W -
                                                         bli_pkg::MV_W){1'b0}}, lo_v});
                    r_den   <= hi_v - lo_v;
                end else begin
                    r_level <= lo_l;                   // below the bottom point
                    r_idx   <= r_idx + 1'b1;
                end
            end
            S_MUL: begin
                r_prod <= {{bli_pkg::MV_W{1'b0}}, r_dl} * {{bli_pkg::LVL_W{1'b0}}, r_dv};
            end
            S_DIV: begin
                if (div_done)
                    r_level <= r_base + div_quo;
            end
            default: begin
            end
        endcase
    end

    bli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIVGO),
        .i_num   (r_prod),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign busy         = r_state != S_IDLE;
    assign o_valid      = r_state == S_OUT;
    assign o_level_pptt = r_level;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the battery level interpolator: a directed table of
// voltage words with pinned levels at the extremes and on the curve points,
// then random words biased towards the curve, each result checked against a
// local piecewise linear level predictor.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W  = bli_pkg::IN_W;
    localparam int LVL_W = bli_pkg::LVL_W;
    localparam int MV_W  = bli_pkg::MV_W;

    localparam int CURVE_POINTS = 21;
    localparam int KNEES        = 21;            // points in the local curve copy
    localparam int SPAN_W       = LVL_W + MV_W;  // level span times voltage offset
    localparam int RANDOM_WORDS = 1330;
    localparam int SETTLE       = 64;
    localparam int CYCLE_LIMIT  = 500000;

    // Discharge curve, highest voltage at index 0.
    localparam logic [KNEES-1:0][MV_W-1:0] KNEE_MV = {
        13'd3270, 13'd3610, 13'd3690, 13'd3710, 13'd3730, 13'd3750, 13'd3770,
        13'd3790, 13'd3800, 13'd3820, 13'd3840, 13'd3850, 13'd3870, 13'd3910,
        13'd3950, 13'd3980, 13'd4020, 13'd4080, 13'd4110, 13'd4150, 13'd4200
    };
    localparam logic [KNEES-1:0][LVL_W-1:0] KNEE_LVL = {
        14'd0,    14'd500,  14'd1000, 14'd1500, 14'd2000, 14'd2500, 14'd3000,
        14'd3500, 14'd4000, 14'd4500, 14'd5000, 14'd5500, 14'd6000, 14'd6500,
        14'd7000, 14'd7500, 14'd8000, 14'd8500, 14'd9000, 14'd9500, 14'd10000
    };

    typedef struct packed {
        logic [IN_W-1:0]  mv;
        logic             pinned;   // level typed in below, else predicted
        logic [LVL_W-1:0] level;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 23;

    // Directed words: extremes of the voltage field, the top and bottom points
    // and their neighbours, exact hits on inner points, and a few in-between.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{16'd0,     1'b1, 14'd0},
        '{16'd65535, 1'b1, 14'd10000},
        '{16'd4200,  1'b1, 14'd10000},
        '{16'd4201,  1'b1, 14'd10000},
        '{16'd32768, 1'b1, 14'd10000},
        '{16'd4199,  1'b0, 14'd0},
        '{16'd3270,  1'b1, 14'd0},
        '{16'd3269,  1'b1, 14'd0},
        '{16'd3271,  1'b0, 14'd0},
        '{16'd3610,  1'b1, 14'd500},
        '{16'd3611,  1'b0, 14'd0},
        '{16'd3609,  1'b0, 14'd0},
        '{16'd3840,  1'b1, 14'd5000},
        '{16'd4150,  1'b1, 14'd9500},
        '{16'd3690,  1'b1, 14'd1000},
        '{16'd3790,  1'b1, 14'd3500},
        '{16'd3700,  1'b0, 14'd0},
        '{16'd3975,  1'b0, 14'd0},
        '{16'd4081,  1'b0, 14'd0},
        '{16'h5555,  1'b1, 14'd10000},
        '{16'h2AAA,  1'b1, 14'd10000},
        '{16'h0FFF,  1'b0, 14'd0},
        '{16'h0CCB,  1'b0, 14'd0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [IN_W-1:0]   i_battery_mv = '0;
    logic              busy;
    logic              o_valid;
    logic [LVL_W-1:0]  o_level_pptt;

    // Pinned level for the word currently offered, read at the accepting edge.
    logic              word_pinned = 1'b0;
    logic [LVL_W-1:0]  word_level = '0;

    logic [LVL_W-1:0]  level_due [$];
    logic [LVL_W-1:0]  level_next;
    int                mismatches = 0;
    int                cycles = 0;
    int                burst_left = 0;

    battery_level_interpolator #(
        .CURVE_POINTS (CURVE_POINTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_battery_mv (i_battery_mv),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_level_pptt (o_level_pptt)
    );

    always #5 i_clk = ~i_clk;

    // Level for a voltage: cap at the top point, floor at the bottom one,
    // otherwise interpolate up from the first point at or below the word,
    // truncating the division.
    function automatic logic [LVL_W-1:0] level_for_mv(input logic [IN_W-1:0] mv);
        int                 n;
        logic [SPAN_W-1:0]  span;
        n = (CURVE_POINTS > KNEES) ? KNEES : CURVE_POINTS;
        if (n < 1)
            n = 1;
        if (mv >= KNEE_MV[0])
            return KNEE_LVL[0];
        for (int i = 1; i < n; i++) begin
            if (mv >= KNEE_MV[i]) begin
                // Flat or inverted segment: take the lower level, no divide.
                if (KNEE_MV[i-1] <= KNEE_MV[i] || KNEE_LVL[i-1] < KNEE_LVL[i])
                    return KNEE_LVL[i];
                span = SPAN_W'(KNEE_LVL[i-1] - KNEE_LVL[i]) *
                       SPAN_W'(mv - KNEE_MV[i]);
                return LVL_W'(KNEE_LVL[i] + span / (KNEE_MV[i-1] - KNEE_MV[i]));
            end
        end
        return KNEE_LVL[n-1];
    endfunction

    // Sender gap: mostly a short random gap, with the odd back-to-back burst.
    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 13);
    endfunction

    // Random voltage: mostly across the curve, some near a point, some anywhere.
    function automatic logic [IN_W-1:0] draw_mv();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return IN_W'($urandom_range(3260, 4210));
        if (pick < 85) begin
            k = $urandom_range(0, KNEES - 1);
            return IN_W'(int'(KNEE_MV[k]) + $urandom_range(0, 2) - 1);
        end
        return IN_W'($urandom);
    endfunction

    // Offer one word after a random gap and hold it until the block takes it.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [IN_W-1:0] mv, input logic pinned,
                             input logic [LVL_W-1:0] level);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        word_pinned = pinned;
        word_level  = level;
        start        <= 1'b1;
        i_battery_mv <= mv;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop start and hold off until every outstanding level has come back.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (level_due.size() != 0);
    endtask

    // Scoreboard: retire the oldest expected level on each strobe first, then
    // queue the level for a word accepted at this same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (level_due.size() == 0) begin
                    $error("level_pptt: no level expected, actual %0d", o_level_pptt);
                    mismatches++;
                end else begin
                    level_next = level_due.pop_front();
                    if (o_level_pptt !== level_next) begin
                        $error("level_pptt: expected %0d, actual %0d",
                               level_next, o_level_pptt);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                level_due.push_back(word_pinned ? word_level : level_for_mv(i_battery_mv));
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        // Hold reset low from the start, release on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_word(directed_rows[r].mv, directed_rows[r].pinned,
                      directed_rows[r].level);

        // Let the block fall fully idle before the random words.
        drain_results();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2)
                drain_results();
            send_word(draw_mv(), 1'b0, '0);
        end

        drain_results();
        // Catch any stray strobe after the last level.
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
